@@ rtl/bcd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcd_pkg
// Shared types and constants of the button click detector.
// ----------------------------------------------------------------------------
package bcd_pkg;

	localparam int NUM_BUTTONS = 2;
	localparam int BTN_W       = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
	localparam int TICK_W      = 16;
	localparam int DEB_W       = 8;
	localparam int REP_W       = 8;
	localparam int CFG_W       = 16;
	localparam int CFG_IDX_W   = 2;
	localparam int DIV_CNT_W   = $clog2(TICK_W);

	localparam logic [REP_W-1:0] REP_MAX = {REP_W{1'b1}};

	typedef enum logic [2:0] {
		PS_IDLE    = 3'd0,
		PS_PRESS   = 3'd1,
		PS_RELEASE = 3'd2,
		PS_REPEAT  = 3'd3,
		PS_LONG    = 3'd4
	} press_t;

	typedef enum logic [2:0] {
		EV_NONE       = 3'd0,
		EV_DOWN       = 3'd1,
		EV_UP         = 3'd2,
		EV_SINGLE     = 3'd3,
		EV_DOUBLE     = 3'd4,
		EV_LONG_START = 3'd5,
		EV_LONG_HOLD  = 3'd6
	} event_t;

	typedef enum logic [1:0] {
		SEQ_IDLE = 2'd0,
		SEQ_LOAD = 2'd1,
		SEQ_DIV  = 2'd2,
		SEQ_DONE = 2'd3
	} seq_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DEBOUNCE = 2'd0,
		REG_LONG     = 2'd1,
		REG_SHORT    = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [DEB_W-1:0]  debounce_ticks;
		logic [TICK_W-1:0] long_press_ticks;
		logic [TICK_W-1:0] short_press_ticks;
	} cfg_t;

	typedef struct packed {
		logic [BTN_W-1:0] button_out;
		event_t           event_res;
		logic             pressed;
	} res_t;

endpackage

@@ rtl/bcd_rem.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcd_rem
// Shift-subtract remainder unit, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bcd_rem (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [bcd_pkg::TICK_W-1:0] dividend,
	input  logic [bcd_pkg::TICK_W-1:0] divisor,
	output logic                       done,
	output logic [bcd_pkg::TICK_W-1:0] remainder
);
	import bcd_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [TICK_W-1:0]    dvd_q;
	logic [TICK_W-1:0]    dsr_q;
	logic [TICK_W-1:0]    rem_q;
	logic [TICK_W:0]      trial;
	logic [TICK_W:0]      diff;
	logic                 fits;

	assign trial = {rem_q, dvd_q[TICK_W-1]};
	assign diff  = trial - {1'b0, dsr_q};
	assign fits  = (trial >= {1'b0, dsr_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(TICK_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[TICK_W-2:0], 1'b0};
			rem_q <= fits ? diff[TICK_W-1:0] : trial[TICK_W-1:0];
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;

endmodule

@@ rtl/bcd_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcd_core
// Sequencer, per-button state and debounce / press event decision.
// ----------------------------------------------------------------------------
module bcd_core (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [bcd_pkg::BTN_W-1:0] in_button,
	input  logic                      in_level,
	input  bcd_pkg::cfg_t             cfg,
	input  logic                      out_free,
	output logic                      res_valid,
	output bcd_pkg::res_t             res
);
	import bcd_pkg::*;

	seq_t seq_q, seq_n;

	logic              rem_start;
	logic              rem_done;
	logic [TICK_W-1:0] rem_val;
	logic              commit;

	logic [BTN_W-1:0] btn_q;
	logic             lvl_q;

	press_t            press_q  [NUM_BUTTONS];
	logic [TICK_W-1:0] tick_q   [NUM_BUTTONS];
	logic [DEB_W-1:0]  deb_q    [NUM_BUTTONS];
	logic              stable_q [NUM_BUTTONS];
	logic [REP_W-1:0]  rep_q    [NUM_BUTTONS];

	press_t            ps, ps_n;
	logic [TICK_W-1:0] tk, tick_n;
	logic [REP_W-1:0]  rep, rep_n;
	logic [DEB_W:0]    deb_inc;
	logic [DEB_W-1:0]  deb_n;
	logic              stable_n;
	logic              active;
	event_t            ev;

	// sequencer
	always_comb begin
		seq_n = seq_q;
		case (seq_q)
			SEQ_IDLE: if (in_valid) seq_n = SEQ_LOAD;
			SEQ_LOAD: seq_n = SEQ_DIV;
			SEQ_DIV:  if (rem_done) seq_n = SEQ_DONE;
			SEQ_DONE: if (out_free) seq_n = SEQ_IDLE;
			default:  seq_n = SEQ_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = 1'b0;
		rem_start = 1'b0;
		commit    = 1'b0;
		case (seq_q)
			SEQ_IDLE: in_ready  = 1'b1;
			SEQ_LOAD: rem_start = 1'b1;
			SEQ_DONE: commit    = out_free;
			default:  ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) seq_q <= SEQ_IDLE;
		else         seq_q <= seq_n;
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			btn_q <= in_button;
			lvl_q <= in_level;
		end
	end

	// state of the selected button, tick already advanced unless the button is idle
	assign ps  = press_q[btn_q];
	assign rep = rep_q[btn_q];
	assign tk  = (ps != PS_IDLE) ? tick_q[btn_q] + 1'b1 : tick_q[btn_q];

	bcd_rem u_rem (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (rem_start),
		.dividend  (tk),
		.divisor   (cfg.short_press_ticks),
		.done      (rem_done),
		.remainder (rem_val)
	);

	// debounce
	always_comb begin
		deb_inc  = {1'b0, deb_q[btn_q]} + 1'b1;
		stable_n = stable_q[btn_q];
		deb_n    = '0;
		if (lvl_q != stable_q[btn_q]) begin
			if (deb_inc >= {1'b0, cfg.debounce_ticks}) stable_n = lvl_q;
			else                                       deb_n    = deb_inc[DEB_W-1:0];
		end
	end

	assign active = !stable_n;

	// press machine
	always_comb begin
		ps_n   = ps;
		tick_n = tk;
		rep_n  = rep;
		ev     = EV_NONE;
		case (ps)
			PS_IDLE: begin
				if (active) begin
					ev     = EV_DOWN;
					tick_n = '0;
					rep_n  = REP_W'(1);
					ps_n   = PS_PRESS;
				end
			end
			PS_PRESS, PS_REPEAT: begin
				if (!active) begin
					ev     = EV_UP;
					tick_n = '0;
					ps_n   = PS_RELEASE;
				end else if (tk > cfg.long_press_ticks) begin
					ev   = EV_LONG_START;
					ps_n = PS_LONG;
				end
			end
			PS_RELEASE: begin
				if (active) begin
					ev     = EV_DOWN;
					tick_n = '0;
					ps_n   = PS_REPEAT;
					if (rep != REP_MAX) rep_n = rep + 1'b1;
				end else if (tk > cfg.short_press_ticks) begin
					if (rep == REP_W'(1))      ev = EV_SINGLE;
					else if (rep == REP_W'(2)) ev = EV_DOUBLE;
					ps_n = PS_IDLE;
				end
			end
			PS_LONG: begin
				if (!active) begin
					ev   = EV_UP;
					ps_n = PS_IDLE;
				end else if (cfg.short_press_ticks != '0 && rem_val == '0) begin
					ev = EV_LONG_HOLD;
				end
			end
			default: ps_n = PS_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_BUTTONS; i++) begin
				press_q[i]  <= PS_IDLE;
				tick_q[i]   <= '0;
				deb_q[i]    <= '0;
				stable_q[i] <= 1'b1;
				rep_q[i]    <= '0;
			end
		end else if (commit) begin
			press_q[btn_q]  <= ps_n;
			tick_q[btn_q]   <= tick_n;
			deb_q[btn_q]    <= deb_n;
			stable_q[btn_q] <= stable_n;
			rep_q[btn_q]    <= rep_n;
		end
	end

	assign res_valid      = commit;
	assign res.button_out = btn_q;
	assign res.event_res  = ev;
	assign res.pressed    = active;

`ifndef SYNTHESIS
	a_accept_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (seq_q == SEQ_LOAD))
		else $error("request accepted but sequencer did not load");

	a_rem_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		rem_done |-> (seq_q == SEQ_DIV))
		else $error("remainder finished outside divide phase");

	a_hold_from_long: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.event_res == EV_LONG_HOLD) |-> (ps == PS_LONG))
		else $error("long hold event outside long press");

	a_rep_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(ps != PS_IDLE) |-> (rep != '0))
		else $error("active press with zero repeat count");

	a_pressed_kept: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |=> (stable_q[$past(btn_q)] == !$past(res.pressed)))
		else $error("stored level disagrees with reported pressed flag");
`endif

endmodule

@@ rtl/button_click_detector.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_click_detector
// Debounce and click / double click / long press detection for buttons.
// ----------------------------------------------------------------------------
//  channel   | dir | contents
//  s_axis    | in  | tuser[0] button, tdata[0] raw_level (0 = pressed)
//  m_axis    | out | tuser[0] button_out, tdata[2:0] event_res, tdata[3] pressed
//  cfg       | in  | cfg_we, cfg_addr (register index), cfg_wdata
//
//  One request passes through accept, load, 16 steps of the shift-subtract
//  remainder unit (hold period check), done handoff and commit.
//  s_axis_tready is low while a request is in work or its result cannot be
//  stored; one finished result waits in the output register.
//  arst_n clears button state, registers to 3 / 100 / 30, and the output.
// ----------------------------------------------------------------------------
module button_click_detector (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [7:0]                    s_axis_tdata,  // [0] raw_level
	input  logic [bcd_pkg::BTN_W-1:0]     s_axis_tuser,  // [0] button
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [7:0]                    m_axis_tdata,  // [2:0] event_res, [3] pressed
	output logic [bcd_pkg::BTN_W-1:0]     m_axis_tuser,  // [0] button_out
	input  logic                          cfg_we,
	input  logic [bcd_pkg::CFG_IDX_W-1:0] cfg_addr,
	input  logic [bcd_pkg::CFG_W-1:0]     cfg_wdata
);
	import bcd_pkg::*;

	cfg_t cfg_q;
	logic out_free;
	logic res_valid;
	res_t res;
	logic out_valid_q;
	res_t out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ticks    <= DEB_W'(3);
			cfg_q.long_press_ticks  <= TICK_W'(100);
			cfg_q.short_press_ticks <= TICK_W'(30);
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_DEBOUNCE: cfg_q.debounce_ticks    <= cfg_wdata[DEB_W-1:0];
				REG_LONG:     cfg_q.long_press_ticks  <= cfg_wdata[TICK_W-1:0];
				REG_SHORT:    cfg_q.short_press_ticks <= cfg_wdata[TICK_W-1:0];
				default:      ;
			endcase
		end
	end

	assign out_free = !out_valid_q || m_axis_tready;

	bcd_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_button (s_axis_tuser),
		.in_level  (s_axis_tdata[0]),
		.cfg       (cfg_q),
		.out_free  (out_free),
		.res_valid (res_valid),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)       out_valid_q <= 1'b0;
		else if (out_free) out_valid_q <= res_valid;
	end

	always_ff @(posedge clk) begin
		if (res_valid && out_free) out_q <= res;
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_q.button_out;
	assign m_axis_tdata  = {4'b0000, out_q.pressed, out_q.event_res};

endmodule
